[hdl/dsel_pkg.sv]
package dsel_pkg;

   localparam int MAX_CANDIDATES = 64;
   localparam int TIME_BITS      = 32;
   localparam int PRIO_BITS      = 8;
   localparam int INDEX_BITS     = 6;
   localparam int MODE_BITS      = 3;
   localparam int POS_BITS       = $clog2(MAX_CANDIDATES);
   localparam int CNT_BITS       = $clog2(MAX_CANDIDATES + 1);
   localparam int PROD_BITS      = 2 * TIME_BITS;
   localparam int ADDR_BITS      = 3;
   localparam int REG_BITS       = ADDR_BITS - 2;
   localparam int DATA_BITS      = 32;

   localparam logic [MODE_BITS-1:0] MODE_FIFO = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_SPT  = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_LPT  = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_EDD  = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_CR   = 3'd4;

   localparam logic [REG_BITS-1:0] REG_POLICY_MODE = 1'b0;

   typedef struct packed {
      logic                 candidate_valid;
      logic                 last_candidate;
      logic [PRIO_BITS-1:0] priority_req;
      logic [TIME_BITS-1:0] enqueue_time;
      logic [TIME_BITS-1:0] process_time;
      logic [TIME_BITS-1:0] due_date;
      logic [TIME_BITS-1:0] remaining_work;
      logic [TIME_BITS-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic                  found;
      logic [INDEX_BITS-1:0] best_index;
      logic                  overflowed;
   } rsp_type;

   typedef struct packed {
      logic [PRIO_BITS-1:0] prio;
      logic [TIME_BITS-1:0] enqueue;
      logic [TIME_BITS-1:0] process;
      logic [TIME_BITS-1:0] due;
      logic [TIME_BITS-1:0] remaining;
   } cand_type;

endpackage

[hdl/dispatch_rule_selector.sv]
// channel  direction  beat        payload
// req      in         candidate   req_type (one candidate or an empty marker)
// rsp      out        selection   rsp_type (one per beat marked last)
// csr      in/out     register    policy_mode at byte 0, APB write, always ready
//
// One candidate a cycle unless stalled: a beat is registered, then compared
// against the held best in the next cycle through the rule compare (two 32x32
// products for CR). A selection is registered as its last beat advances and
// holds until taken. Synchronous active-high reset clears control state and
// sets FIFO mode. A waiting selection stalls only a last beat; others flow on.
module dispatch_rule_selector import dsel_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   logic                 stage_valid_ff, stage_valid_in;
   req_type              stage_ff;
   logic                 stage_advance;
   logic [MODE_BITS-1:0] mode_ff;
   logic [CNT_BITS-1:0]  seen_count_ff, seen_count_in;
   logic                 have_best_ff, have_best_in;
   logic                 overflow_ff, overflow_in;
   logic [POS_BITS-1:0]  best_pos_ff, best_pos_in;
   cand_type             best_ff, best_in;
   logic [TIME_BITS-1:0] held_now_ff, held_now_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   cand_type             cand;
   logic                 beats;
   logic                 has_room;
   logic                 take;
   logic                 replace;
   logic                 csr_write;
   logic [REG_BITS-1:0]  reg_index;

   assign stage_advance = stage_valid_ff &&
                          (!stage_ff.last_candidate || !rsp_valid_ff || rsp_ready);
   assign req_ready     = !stage_valid_ff || stage_advance;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_valid && req_ready) begin
         stage_valid_in = 1'b1;
      end else if (stage_advance) begin
         stage_valid_in = 1'b0;
      end
   end

   assign cand.prio      = stage_ff.priority_req;
   assign cand.enqueue   = stage_ff.enqueue_time;
   assign cand.process   = stage_ff.process_time;
   assign cand.due       = stage_ff.due_date;
   assign cand.remaining = stage_ff.remaining_work;

   dsel_compare u_compare (
      .mode     (mode_ff),
      .cand     (cand),
      .best     (best_ff),
      .held_now (held_now_ff),
      .beats    (beats)
   );

   assign has_room = seen_count_ff < CNT_BITS'(MAX_CANDIDATES);
   assign take     = stage_ff.candidate_valid && has_room;
   assign replace  = take && (!have_best_ff || beats);

   always_comb begin
      seen_count_in = seen_count_ff;
      have_best_in  = have_best_ff;
      overflow_in   = overflow_ff;
      best_pos_in   = best_pos_ff;
      best_in       = best_ff;
      held_now_in   = held_now_ff;
      if (stage_ff.candidate_valid && !has_room) begin
         overflow_in = 1'b1;
      end
      if (take) begin
         seen_count_in = seen_count_ff + CNT_BITS'(1);
         if (seen_count_ff == '0) begin
            held_now_in = stage_ff.now_time;
         end
      end
      if (replace) begin
         have_best_in = 1'b1;
         best_pos_in  = seen_count_ff[POS_BITS-1:0];
         best_in      = cand;
      end
      rsp_in.found      = have_best_in;
      rsp_in.best_index = have_best_in ? INDEX_BITS'(best_pos_in) : '0;
      rsp_in.overflowed = overflow_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (stage_advance && stage_ff.last_candidate) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign reg_index = paddr[ADDR_BITS-1:2];
   assign csr_write = psel && penable && pwrite && (reg_index == REG_POLICY_MODE);
   assign pready    = 1'b1;
   assign prdata    = (reg_index == REG_POLICY_MODE) ? DATA_BITS'(mode_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         mode_ff        <= MODE_FIFO;
         seen_count_ff  <= '0;
         have_best_ff   <= 1'b0;
         overflow_ff    <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_write) begin
            mode_ff <= pwdata[MODE_BITS-1:0];
         end
         if (stage_advance) begin
            if (stage_ff.last_candidate) begin
               seen_count_ff <= '0;
               have_best_ff  <= 1'b0;
               overflow_ff   <= 1'b0;
            end else begin
               seen_count_ff <= seen_count_in;
               have_best_ff  <= have_best_in;
               overflow_ff   <= overflow_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_ff <= req_data;
      end
      if (stage_advance) begin
         best_pos_ff <= best_pos_in;
         best_ff     <= best_in;
         held_now_ff <= held_now_in;
      end
      if (stage_advance && stage_ff.last_candidate) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      seen_count_ff <= CNT_BITS'(MAX_CANDIDATES))
      else $error("candidate count beyond capacity");

   a_have_best_count: assert property (@(posedge clock) disable iff (reset)
      have_best_ff == (seen_count_ff != '0))
      else $error("held best out of step with candidate count");

   a_set_clears: assert property (@(posedge clock) disable iff (reset)
      stage_advance && stage_ff.last_candidate |=>
         seen_count_ff == '0 && !have_best_ff && !overflow_ff)
      else $error("set state not cleared after last beat");

   a_empty_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.found |-> rsp_ff.best_index == '0)
      else $error("empty set reports a nonzero index");

   a_overflow_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.overflowed |-> rsp_ff.found)
      else $error("overflow reported without a candidate");
`endif

endmodule

[hdl/dsel_compare.sv]
module dsel_compare import dsel_pkg::*; (
   input  logic [MODE_BITS-1:0] mode,
   input  cand_type             cand,
   input  cand_type             best,
   input  logic [TIME_BITS-1:0] held_now,
   output logic                 beats
);

   logic                        fifo_better;
   logic                        x_neg;
   logic                        y_neg;
   logic [TIME_BITS-1:0]        x_mag;
   logic [TIME_BITS-1:0]        y_mag;
   logic [PROD_BITS-1:0]        prod_x;
   logic [PROD_BITS-1:0]        prod_y;
   logic signed [PROD_BITS:0]   x_val;
   logic signed [PROD_BITS:0]   y_val;

   assign fifo_better = (cand.prio != best.prio) ? (cand.prio > best.prio)
                                                 : (cand.enqueue < best.enqueue);

   // signed slack times the other side's remaining work
   assign x_neg  = cand.due < held_now;
   assign y_neg  = best.due < held_now;
   assign x_mag  = x_neg ? (held_now - cand.due) : (cand.due - held_now);
   assign y_mag  = y_neg ? (held_now - best.due) : (best.due - held_now);
   assign prod_x = PROD_BITS'(x_mag) * PROD_BITS'(best.remaining);
   assign prod_y = PROD_BITS'(y_mag) * PROD_BITS'(cand.remaining);
   assign x_val  = x_neg ? $signed((PROD_BITS+1)'(0) - {1'b0, prod_x}) : $signed({1'b0, prod_x});
   assign y_val  = y_neg ? $signed((PROD_BITS+1)'(0) - {1'b0, prod_y}) : $signed({1'b0, prod_y});

   always_comb begin
      case (mode)
         MODE_SPT: begin
            beats = (cand.process != best.process) ? (cand.process < best.process)
                                                   : fifo_better;
         end
         MODE_LPT: begin
            beats = (cand.process != best.process) ? (cand.process > best.process)
                                                   : fifo_better;
         end
         MODE_EDD: begin
            beats = (cand.due != best.due) ? (cand.due < best.due) : fifo_better;
         end
         MODE_CR: begin
            if (cand.remaining == '0) begin
               beats = 1'b0;
            end else if (best.remaining == '0) begin
               beats = 1'b1;
            end else if (x_val != y_val) begin
               beats = x_val < y_val;
            end else begin
               beats = fifo_better;
            end
         end
         default: begin
            beats = fifo_better;
         end
      endcase
   end

endmodule

[bench/tb_top.sv]
module tb_top import dsel_pkg::*; ();

   localparam int RANDOM_ITEMS = 950;
   localparam int PHASE_ITEMS  = 80;
   localparam int SETTLE       = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 60;
   localparam int WATCHDOG     = 3000;
   localparam int MAX_REPORTS  = 30;
   localparam int KEEP_MODE    = -1;

   localparam logic [MODE_BITS-1:0] MODE_UNUSED_TOP = 3'd7;
   localparam logic [TIME_BITS-1:0] TICK_MAX        = '1;

   typedef struct {
      int      mode;
      req_type beat;
      bit      typed;
      rsp_type sel;
   } dir_row_type;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 psel      = 1'b0;
   logic                 penable   = 1'b0;
   logic                 pwrite    = 1'b0;
   logic [ADDR_BITS-1:0] paddr     = '0;
   logic [DATA_BITS-1:0] pwdata    = '0;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   dispatch_rule_selector dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // selector model state
   logic [MODE_BITS-1:0] cur_mode     = MODE_FIFO;
   cand_type             held         = '0;
   logic [POS_BITS-1:0]  held_pos     = '0;
   logic [CNT_BITS-1:0]  cand_seen    = '0;
   bit                   held_valid   = 1'b0;
   logic [TIME_BITS-1:0] set_now      = '0;
   bit                   set_overflow = 1'b0;

   rsp_type     pending_sel[$];
   dir_row_type dir_rows[$];
   int          errors       = 0;
   int          sel_seen     = 0;
   int          random_items = 0;
   int          idle_cycles  = 0;
   bit          hold_done    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit fifo_wins(cand_type c);
      if (c.prio != held.prio) return c.prio > held.prio;
      return c.enqueue < held.enqueue;
   endfunction

   function automatic bit beats_held(cand_type c);
      logic signed [TIME_BITS+1:0]   new_slack, old_slack;
      logic signed [2*TIME_BITS+3:0] lhs, rhs;
      case (cur_mode)
         MODE_SPT: if (c.process != held.process) return c.process < held.process;
         MODE_LPT: if (c.process != held.process) return c.process > held.process;
         MODE_EDD: if (c.due != held.due) return c.due < held.due;
         MODE_CR: begin
            if (c.remaining == '0) return 1'b0;
            if (held.remaining == '0) return 1'b1;
            new_slack = $signed({2'b00, c.due}) - $signed({2'b00, set_now});
            old_slack = $signed({2'b00, held.due}) - $signed({2'b00, set_now});
            lhs = new_slack * $signed({1'b0, held.remaining});
            rhs = old_slack * $signed({1'b0, c.remaining});
            if (lhs != rhs) return lhs < rhs;
         end
         default: ;
      endcase
      return fifo_wins(c);
   endfunction

   task automatic track_candidate(input req_type b, output bit closes, output rsp_type sel);
      cand_type c;
      c.prio      = b.priority_req;
      c.enqueue   = b.enqueue_time;
      c.process   = b.process_time;
      c.due       = b.due_date;
      c.remaining = b.remaining_work;
      closes      = b.last_candidate;
      sel         = '0;
      if (b.candidate_valid) begin
         if (cand_seen >= MAX_CANDIDATES) begin
            set_overflow = 1'b1;
         end else begin
            if (cand_seen == 0) set_now = b.now_time;
            if (!held_valid || beats_held(c)) begin
               held_valid = 1'b1;
               held_pos   = POS_BITS'(cand_seen);
               held       = c;
            end
            cand_seen++;
         end
      end
      if (closes) begin
         sel.found      = held_valid;
         sel.best_index = held_valid ? INDEX_BITS'(held_pos) : '0;
         sel.overflowed = set_overflow;
         held         = '0;
         held_pos     = '0;
         cand_seen    = '0;
         held_valid   = 1'b0;
         set_now      = '0;
         set_overflow = 1'b0;
      end
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [TIME_BITS-1:0] rand_tick();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return TICK_MAX;
         2, 3, 4: return TIME_BITS'($urandom_range(0, 15));
         5, 6:    return TIME_BITS'($urandom_range(0, 2000));
         default: return TIME_BITS'($urandom);
      endcase
   endfunction

   function automatic req_type mk_beat(bit v, bit l, logic [PRIO_BITS-1:0] p,
                                       logic [TIME_BITS-1:0] enq, logic [TIME_BITS-1:0] proc,
                                       logic [TIME_BITS-1:0] due, logic [TIME_BITS-1:0] rem,
                                       logic [TIME_BITS-1:0] now);
      req_type b;
      b.candidate_valid = v;
      b.last_candidate  = l;
      b.priority_req    = p;
      b.enqueue_time    = enq;
      b.process_time    = proc;
      b.due_date        = due;
      b.remaining_work  = rem;
      b.now_time        = now;
      return b;
   endfunction

   task automatic add_row(input int mode, input req_type b, input bit typed, input rsp_type sel);
      dir_row_type r;
      r.mode  = mode;
      r.beat  = b;
      r.typed = typed;
      r.sel   = sel;
      dir_rows.push_back(r);
   endtask

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
   endtask

   // drain, then write and read back the mode
   task automatic set_mode(input logic [MODE_BITS-1:0] m);
      req_valid <= 1'b0;
      while (pending_sel.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_POLICY_MODE, 2'b00};
      pwdata  <= DATA_BITS'(m);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== DATA_BITS'(m)) report_field("policy_mode readback", m, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      cur_mode = m;
   endtask

   task automatic send_beat(input req_type b, input bit quiet, input bit typed,
                            input rsp_type tsel);
      int      n;
      bit      closes;
      rsp_type sel;
      n = quiet ? 0 : gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_candidate(b, closes, sel);
      if (closes) pending_sel.push_back(typed ? tsel : sel);
   endtask

   task automatic random_set(input int size, input bit quiet);
      req_type b;
      bit      empty;
      empty = ($urandom_range(0, 19) == 0);
      for (int k = 0; k < size; k++) begin
         b.candidate_valid = !empty && ($urandom_range(0, 9) != 0);
         b.last_candidate  = (k == size - 1);
         b.priority_req    = $urandom_range(0, 1) ? PRIO_BITS'($urandom_range(0, 3))
                                                  : PRIO_BITS'($urandom);
         b.enqueue_time    = rand_tick();
         b.process_time    = rand_tick();
         b.due_date        = rand_tick();
         b.remaining_work  = rand_tick();
         b.now_time        = rand_tick();
         send_beat(b, quiet, 1'b0, '0);
         random_items++;
      end
   endtask

   initial begin : stimulus
      int start_items;
      int size;
      bit quiet;
      bit first;

      add_row(KEEP_MODE, mk_beat(0, 1, 0, 0, 0, 0, 0, 0), 1, rsp_type'({1'b0, 6'd0, 1'b0}));
      add_row(KEEP_MODE, mk_beat(1, 1, 8'hFF, TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX),
              1, rsp_type'({1'b1, 6'd0, 1'b0}));
      add_row(KEEP_MODE, mk_beat(1, 0, 10, 5, 0, 0, 0, 0), 0, '0);
      add_row(KEEP_MODE, mk_beat(1, 0, 10, 3, 0, 0, 0, 0), 0, '0);
      add_row(KEEP_MODE, mk_beat(1, 1, 0, 0, 0, 0, 0, 0), 0, '0);
      add_row(MODE_SPT, mk_beat(1, 0, 0, 0, 100, 0, 0, 0), 0, '0);
      add_row(KEEP_MODE, mk_beat(1, 0, 0, 0, 50, 0, 0, 0), 0, '0);
      add_row(KEEP_MODE, mk_beat(1, 1, 9, 0, 50, 0, 0, 0), 0, '0);
      add_row(MODE_LPT, mk_beat(1, 0, 0, 0, 0, 0, 0, 0), 0, '0);
      add_row(KEEP_MODE, mk_beat(1, 1, 0, 0, TICK_MAX, 0, 0, 0), 0, '0);
      add_row(MODE_EDD, mk_beat(1, 0, 0, 0, 0, 500, 0, 0), 0, '0);
      add_row(KEEP_MODE, mk_beat(0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
      add_row(KEEP_MODE, mk_beat(1, 0, 0, 0, 0, 100, 0, 0), 0, '0);
      add_row(KEEP_MODE, mk_beat(0, 1, 0, 0, 0, 0, 0, 0), 0, '0);
      add_row(MODE_CR, mk_beat(1, 0, 0, 0, 0, 5000, 0, 1000), 0, '0);
      add_row(KEEP_MODE, mk_beat(1, 0, 7, 0, 0, 0, 0, 0), 0, '0);
      add_row(KEEP_MODE, mk_beat(1, 0, 0, 0, 0, 900, 10, 9), 0, '0);
      add_row(KEEP_MODE, mk_beat(1, 0, 0, 0, 0, 2000, 1, 0), 0, '0);
      add_row(KEEP_MODE, mk_beat(1, 0, 3, 0, 0, 800, 20, 0), 0, '0);
      add_row(KEEP_MODE, mk_beat(1, 1, 0, 0, 0, TICK_MAX, TICK_MAX, 0), 0, '0);
      add_row(MODE_UNUSED_TOP, mk_beat(1, 0, 1, 20, 0, 0, 0, 0), 0, '0);
      add_row(KEEP_MODE, mk_beat(1, 1, 1, 10, 0, 0, 0, 0), 0, '0);
      add_row(MODE_SPT, mk_beat(1, 0, 0, 0, 10, 0, 0, 0), 0, '0);
      add_row(MODE_FIFO, mk_beat(1, 1, 5, 0, 20, 0, 0, 0), 0, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].mode != KEEP_MODE) set_mode(MODE_BITS'(dir_rows[i].mode));
         send_beat(dir_rows[i].beat, 1'b0, dir_rows[i].typed, dir_rows[i].sel);
      end

      for (int ph = 0; random_items < RANDOM_ITEMS; ph++) begin
         set_mode(MODE_BITS'(ph < 8 ? ph : $urandom_range(0, 7)));
         quiet       = (ph % 3 == 1);
         start_items = random_items;
         first       = 1'b1;
         while (random_items - start_items < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
            if ((first && ph % 7 == 2) || $urandom_range(0, 39) == 0)
               size = $urandom_range(62, 80);
            else
               size = $urandom_range(1, 8);
            random_set(size, quiet);
            first = 1'b0;
         end
      end

      req_valid <= 1'b0;
      while (pending_sel.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin : sink
      @(posedge clock);
      forever begin
         if (!hold_done && sel_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  rsp_ready <= 1'b1;
                  repeat ($urandom_range(10, 60)) @(posedge clock);
               end
               9: begin
                  rsp_ready <= 1'b0;
                  repeat ($urandom_range(8, 40)) @(posedge clock);
               end
               default: begin
                  repeat ($urandom_range(4, 20)) begin
                     rsp_ready <= ($urandom_range(0, 3) != 0);
                     @(posedge clock);
                  end
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_sel
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         sel_seen++;
         if (pending_sel.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: selection beat with none expected, actual %p", $time, rsp_data);
         end else begin
            want = pending_sel.pop_front();
            if (rsp_data.found !== want.found)
               report_field("found", want.found, rsp_data.found);
            if (rsp_data.best_index !== want.best_index)
               report_field("best_index", want.best_index, rsp_data.best_index);
            if (rsp_data.overflowed !== want.overflowed)
               report_field("overflowed", want.overflowed, rsp_data.overflowed);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule

[dispatch_rule_selector.f]
hdl/dsel_pkg.sv
hdl/dsel_compare.sv
hdl/dispatch_rule_selector.sv
bench/tb_top.sv
